// ----- design/asc_pkg.sv -----
// Shared types, constants and helper functions for the Ascon-128 AEAD core.
package asc_pkg;

    typedef logic [4:0][63:0] t_state;

    localparam int unsigned NUM_ROUNDS  = 12;
    localparam int unsigned INIT_ROUNDS = 12;
    localparam int unsigned DATA_ROUNDS = 6;

    localparam logic [3:0] INIT_START = 4'(NUM_ROUNDS - INIT_ROUNDS);
    localparam logic [3:0] DATA_START = 4'(NUM_ROUNDS - DATA_ROUNDS);
    localparam logic [3:0] LAST_RND   = 4'(NUM_ROUNDS - 1);

    localparam logic [63:0] ASCON_IV = 64'h80400C0600000000;
    localparam logic [63:0] PAD_TOP  = 64'h8000000000000000;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    localparam logic [3:0] FULL_BYTES = 4'd8;

    // stream widths
    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_DATA_W = 72;

    // configuration port
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 64;
    localparam logic [1:0]  REG_KEY_HI = 2'd0;
    localparam logic [1:0]  REG_KEY_LO = 2'd1;
    localparam logic [1:0]  REG_DEC    = 2'd2;

    // commands
    localparam logic [2:0] CMD_NONCE_HI = 3'd0;
    localparam logic [2:0] CMD_NONCE_LO = 3'd1;
    localparam logic [2:0] CMD_AD       = 3'd2;
    localparam logic [2:0] CMD_TEXT     = 3'd3;
    localparam logic [2:0] CMD_FIN_HI   = 3'd4;
    localparam logic [2:0] CMD_FIN_LO   = 3'd5;

    function automatic logic [7:0] round_const(input logic [3:0] idx);
        logic [7:0] rc;
        case (idx)
            4'd0:    rc = 8'hf0;
            4'd1:    rc = 8'he1;
            4'd2:    rc = 8'hd2;
            4'd3:    rc = 8'hc3;
            4'd4:    rc = 8'hb4;
            4'd5:    rc = 8'ha5;
            4'd6:    rc = 8'h96;
            4'd7:    rc = 8'h87;
            4'd8:    rc = 8'h78;
            4'd9:    rc = 8'h69;
            4'd10:   rc = 8'h5a;
            4'd11:   rc = 8'h4b;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // top n bytes set, n in 0..8
    function automatic logic [63:0] top_mask(input logic [3:0] n);
        logic [63:0] m;
        if (n >= FULL_BYTES) m = ALL_ONES;
        else                 m = ~(ALL_ONES >> {n[2:0], 3'b000});
        return m;
    endfunction

    // 10* padding bit right after n bytes
    function automatic logic [63:0] pad_bit(input logic [2:0] n);
        return PAD_TOP >> {n, 3'b000};
    endfunction

endpackage

// ----- design/ascon128_aead_core.sv -----
// Ascon-128 AEAD core: command sequencer around one shared permutation round.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s_axis   | in  | tvalid/tready          | tdata: data_word, byte_count; tuser: cmd;
//           |     |                        | tlast: last
//  m_axis   | out | tvalid/tready          | tdata: data_out, out_bytes, tag_ok;
//           |     |                        | tuser: is_tag; tlast: final_word
//  apb      | in  | psel/penable, pready=1 | key_hi @0x00, key_lo @0x08, decrypt_mode @0x10
//
//  One permutation round per cycle in asc_round. Per beat: nonce low runs the init
//  rounds, an assoc word the data rounds (a full last word also a padding block), a full
//  text word the data rounds, final high the final rounds; text and final high close open
//  assoc data first. s_axis_tready is high only while the sequencer is idle.
//  The result sits in an output register; a new result waits there for m_axis_tready.
//  Reset is synchronous, active low; it clears the sequencer, phase, keys and mode.
module ascon128_aead_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [asc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // data_word, byte_count, pad
    input  logic [asc_pkg::IN_USER_W-1:0]    s_axis_tuser,  // cmd
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [asc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // data_out, out_bytes, tag_ok, pad
    output logic                             m_axis_tuser,  // is_tag
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [asc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [asc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [asc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import asc_pkg::*;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        is_tag;
        logic        fin;
        logic        ok;
    } t_result;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_NONCE   = 3'd1;
    localparam logic [2:0] PH_AD_NEW  = 3'd2;
    localparam logic [2:0] PH_AD_MORE = 3'd3;
    localparam logic [2:0] PH_TEXT    = 3'd4;
    localparam logic [2:0] PH_FIN_HI  = 3'd5;
    localparam logic [2:0] PH_FIN_LO  = 3'd6;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLOSE = 3'd1;
    localparam logic [2:0] ST_TEXT  = 3'd2;
    localparam logic [2:0] ST_FINP  = 3'd3;
    localparam logic [2:0] ST_MAIN  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [63:0] r_key_hi, n_key_hi;
    logic [63:0] r_key_lo, n_key_lo;
    logic        r_dec, n_dec;
    t_state      r_x, n_x;
    logic [63:0] r_nonce, n_nonce;
    logic [2:0]  r_phase, n_phase;
    logic        r_tmh, n_tmh;
    logic [2:0]  r_st, n_st;
    logic [3:0]  r_rnd, n_rnd;
    logic [2:0]  r_cmd, n_cmd;
    logic [63:0] r_w, n_w;
    logic [3:0]  r_n, n_n;
    logic        r_last, n_last;
    t_result     r_res, n_res;
    logic        r_pend, n_pend;
    t_result     r_out, n_out;
    logic        r_ovalid, n_ovalid;

    t_state      w_rnd_x;
    logic        rnd_last;
    logic        accept;
    logic        cfg_wr;
    logic [2:0]  in_cmd;
    logic [63:0] in_w;
    logic [3:0]  in_raw_n;
    logic [3:0]  in_n;
    logic        in_ad_ph;
    logic [63:0] m_r;
    logic [63:0] p_r;
    logic [63:0] tag_t;

    asc_round u_round (
        .i_x  (r_x),
        .i_rc (round_const(r_rnd)),
        .o_x  (w_rnd_x)
    );

    assign s_axis_tready = (r_st == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign rnd_last      = (r_rnd == LAST_RND);

    assign in_cmd   = s_axis_tuser;
    assign in_w     = s_axis_tdata[63:0];
    assign in_raw_n = s_axis_tdata[67:64];
    assign in_n     = !s_axis_tlast ? FULL_BYTES :
                      (in_raw_n > FULL_BYTES) ? FULL_BYTES : in_raw_n;
    assign in_ad_ph = (r_phase == PH_AD_NEW) || (r_phase == PH_AD_MORE);

    assign m_r   = top_mask(r_n);
    assign p_r   = pad_bit(r_n[2:0]);
    assign tag_t = w_rnd_x[3] ^ r_key_hi;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        unique case (paddr[4:3])
            REG_KEY_HI: prdata = r_key_hi;
            REG_KEY_LO: prdata = r_key_lo;
            REG_DEC:    prdata = {63'd0, r_dec};
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        n_key_hi = r_key_hi;
        n_key_lo = r_key_lo;
        n_dec    = r_dec;
        if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_KEY_HI: n_key_hi = pwdata;
                REG_KEY_LO: n_key_lo = pwdata;
                REG_DEC:    n_dec    = pwdata[0];
                default:    n_dec    = r_dec;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_x      = r_x;
        n_nonce  = r_nonce;
        n_phase  = r_phase;
        n_tmh    = r_tmh;
        n_st     = r_st;
        n_rnd    = r_rnd;
        n_cmd    = r_cmd;
        n_w      = r_w;
        n_n      = r_n;
        n_last   = r_last;
        n_res    = r_res;
        n_pend   = r_pend;
        n_out    = r_out;
        n_ovalid = r_ovalid;

        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;

        unique case (r_st)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd  = in_cmd;
                    n_w    = in_w;
                    n_n    = in_n;
                    n_last = s_axis_tlast;
                    unique case (in_cmd)
                        CMD_NONCE_HI: begin
                            n_nonce = in_w;
                            n_phase = PH_NONCE;
                        end
                        CMD_NONCE_LO: begin
                            if (r_phase == PH_NONCE) begin
                                n_x[0] = ASCON_IV;
                                n_x[1] = r_key_hi;
                                n_x[2] = r_key_lo;
                                n_x[3] = r_nonce;
                                n_x[4] = in_w;
                                n_rnd  = INIT_START;
                                n_st   = ST_MAIN;
                            end
                        end
                        CMD_AD: begin
                            if (in_ad_ph) begin
                                if (in_n == FULL_BYTES) begin
                                    n_x[0] = r_x[0] ^ in_w;
                                    n_rnd  = DATA_START;
                                    n_st   = ST_MAIN;
                                end else if (in_n != 4'd0) begin
                                    n_x[0] = r_x[0] ^ (in_w & top_mask(in_n))
                                             ^ pad_bit(in_n[2:0]);
                                    n_rnd  = DATA_START;
                                    n_st   = ST_MAIN;
                                end else if (r_phase == PH_AD_MORE) begin
                                    n_x[0] = r_x[0] ^ PAD_TOP;
                                    n_rnd  = DATA_START;
                                    n_st   = ST_CLOSE;
                                end else begin
                                    n_x[4]  = r_x[4] ^ 64'd1;
                                    n_phase = PH_TEXT;
                                end
                            end
                        end
                        CMD_TEXT, CMD_FIN_HI: begin
                            if (in_ad_ph || r_phase == PH_TEXT ||
                                (in_cmd == CMD_FIN_HI && r_phase == PH_FIN_HI)) begin
                                if (r_phase == PH_AD_MORE) begin
                                    n_x[0] = r_x[0] ^ PAD_TOP;
                                    n_rnd  = DATA_START;
                                    n_st   = ST_CLOSE;
                                end else begin
                                    if (r_phase == PH_AD_NEW) begin
                                        n_x[4]  = r_x[4] ^ 64'd1;
                                        n_phase = PH_TEXT;
                                    end
                                    n_st = (in_cmd == CMD_TEXT) ? ST_TEXT : ST_FINP;
                                end
                            end
                        end
                        CMD_FIN_LO: begin
                            if (r_phase == PH_FIN_LO) begin
                                n_res.data   = r_x[4] ^ r_key_lo;
                                n_res.nbytes = FULL_BYTES;
                                n_res.is_tag = 1'b1;
                                n_res.fin    = 1'b1;
                                n_res.ok     = r_dec && r_tmh && ((r_x[4] ^ r_key_lo) == in_w);
                                n_pend       = 1'b1;
                                n_phase      = PH_IDLE;
                                n_st         = ST_DONE;
                            end
                        end
                        default: n_st = ST_IDLE;
                    endcase
                end
            end
            ST_CLOSE: begin
                n_x   = w_rnd_x;
                n_rnd = r_rnd + 4'd1;
                if (rnd_last) begin
                    n_x[4]  = w_rnd_x[4] ^ 64'd1;
                    n_phase = PH_TEXT;
                    if (r_cmd == CMD_TEXT)        n_st = ST_TEXT;
                    else if (r_cmd == CMD_FIN_HI) n_st = ST_FINP;
                    else                          n_st = ST_DONE;
                end
            end
            ST_TEXT: begin
                n_res.data   = (r_x[0] ^ r_w) & m_r;
                n_res.nbytes = r_n;
                n_res.is_tag = 1'b0;
                n_res.fin    = 1'b0;
                n_res.ok     = 1'b0;
                n_pend       = 1'b1;
                if (r_n == FULL_BYTES) begin
                    n_x[0] = r_dec ? r_w : (r_x[0] ^ r_w);
                    n_rnd  = DATA_START;
                    n_st   = ST_MAIN;
                end else begin
                    // partial last word: padded, no permutation before finalization
                    n_x[0]  = (r_dec ? ((r_x[0] & ~m_r) | (r_w & m_r))
                                     : (r_x[0] ^ (r_w & m_r))) ^ p_r;
                    n_phase = PH_FIN_HI;
                    n_st    = ST_DONE;
                end
            end
            ST_FINP: begin
                if (r_phase == PH_TEXT) begin
                    n_x[0] = r_x[0] ^ PAD_TOP;
                end
                n_phase = PH_FIN_HI;
                n_x[1]  = r_x[1] ^ r_key_hi;
                n_x[2]  = r_x[2] ^ r_key_lo;
                n_rnd   = INIT_START;
                n_st    = ST_MAIN;
            end
            ST_MAIN: begin
                n_x   = w_rnd_x;
                n_rnd = r_rnd + 4'd1;
                if (rnd_last) begin
                    n_st = ST_DONE;
                    unique case (r_cmd)
                        CMD_NONCE_LO: begin
                            n_x[3]  = w_rnd_x[3] ^ r_key_hi;
                            n_x[4]  = w_rnd_x[4] ^ r_key_lo;
                            n_phase = PH_AD_NEW;
                        end
                        CMD_AD: begin
                            if (r_n == FULL_BYTES) begin
                                n_phase = PH_AD_MORE;
                                if (r_last) begin
                                    // full last word: separate padding block
                                    n_x[0] = w_rnd_x[0] ^ PAD_TOP;
                                    n_rnd  = DATA_START;
                                    n_st   = ST_CLOSE;
                                end
                            end else begin
                                n_x[4]  = w_rnd_x[4] ^ 64'd1;
                                n_phase = PH_TEXT;
                            end
                        end
                        CMD_TEXT: begin
                            if (r_last) begin
                                n_x[0]  = w_rnd_x[0] ^ PAD_TOP;
                                n_phase = PH_FIN_HI;
                            end
                        end
                        CMD_FIN_HI: begin
                            n_res.data   = tag_t;
                            n_res.nbytes = FULL_BYTES;
                            n_res.is_tag = 1'b1;
                            n_res.fin    = 1'b0;
                            n_res.ok     = 1'b0;
                            n_pend       = 1'b1;
                            n_tmh        = r_dec && (tag_t == r_w);
                            n_phase      = PH_FIN_LO;
                        end
                        default: n_st = ST_DONE;
                    endcase
                end
            end
            ST_DONE: begin
                if (!r_pend) begin
                    n_st = ST_IDLE;
                end else if (!r_ovalid || m_axis_tready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_pend   = 1'b0;
                    n_st     = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_dec    <= 1'b0;
            r_phase  <= PH_IDLE;
            r_st     <= ST_IDLE;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_key_hi <= n_key_hi;
            r_key_lo <= n_key_lo;
            r_dec    <= n_dec;
            r_phase  <= n_phase;
            r_st     <= n_st;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_nonce <= n_nonce;
        r_tmh   <= n_tmh;
        r_rnd   <= n_rnd;
        r_cmd   <= n_cmd;
        r_w     <= n_w;
        r_n     <= n_n;
        r_last  <= n_last;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_out.ok, r_out.nbytes, r_out.data};
    assign m_axis_tuser  = r_out.is_tag;
    assign m_axis_tlast  = r_out.fin;

endmodule

// ----- design/asc_round.sv -----
// One Ascon permutation round: constant addition, S-box layer and linear layer.
module asc_round (
    input  asc_pkg::t_state i_x,
    input  logic [7:0]      i_rc,
    output asc_pkg::t_state o_x
);
    import asc_pkg::*;

    function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned r);
        return (v >> r) | (v << (64 - r));
    endfunction

    t_state s;
    t_state t;

    always_comb begin
        s = i_x;
        s[2] = s[2] ^ {56'd0, i_rc};
        // S-box, bit-sliced
        s[0] = s[0] ^ s[4];
        s[4] = s[4] ^ s[3];
        s[2] = s[2] ^ s[1];
        t[0] = ~s[0] & s[1];
        t[1] = ~s[1] & s[2];
        t[2] = ~s[2] & s[3];
        t[3] = ~s[3] & s[4];
        t[4] = ~s[4] & s[0];
        s[0] = s[0] ^ t[1];
        s[1] = s[1] ^ t[2];
        s[2] = s[2] ^ t[3];
        s[3] = s[3] ^ t[4];
        s[4] = s[4] ^ t[0];
        s[1] = s[1] ^ s[0];
        s[0] = s[0] ^ s[4];
        s[3] = s[3] ^ s[2];
        s[2] = ~s[2];
        // linear diffusion
        o_x[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
        o_x[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
        o_x[2] = s[2] ^ rotr(s[2], 1)  ^ rotr(s[2], 6);
        o_x[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
        o_x[4] = s[4] ^ rotr(s[4], 7)  ^ rotr(s[4], 41);
    end

endmodule

// ----- design/asc_chk.sv -----
// Port-level checker for the Ascon-128 AEAD core, bound to the top level.
module asc_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [asc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [asc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser,
    input logic                           m_axis_tlast
);
    import asc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // end of message is always the low tag half, a full word
    a_last_is_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser && m_axis_tdata[67:64] == FULL_BYTES)
        else $error("final beat is not a full tag word");

    // tag match flag only rides on the final beat
    a_ok_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[68] |-> m_axis_tlast)
        else $error("tag_ok set outside the final beat");

    // the core stays ready after accepting nonce high
    a_nonce_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_NONCE_HI |=> s_axis_tready)
        else $error("busy after nonce high");

endmodule

bind ascon128_aead_core asc_chk u_asc_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/ascon128_aead_core_tb.sv -----
// Self-checking testbench for the Ascon-128 AEAD core: stream stimulus, APB key setup.
module ascon128_aead_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_RSVD6     = 3'd6;
    localparam logic [2:0] CMD_RSVD7     = 3'd7;
    localparam int         SEGMENTS      = 6;
    localparam int         SEG_ITEMS     = 288;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         HOLD_CYCLES   = 400;
    localparam int         QUIET_LIMIT   = 3000;
    localparam int         PERM_ROUNDS   = 12;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NONCE, ST_AD_NEW, ST_AD_MORE, ST_TEXT, ST_FIN_HI, ST_FIN_LO
    } t_aead_phase;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        is_tag;
        logic        fin;
        logic        ok;
    } t_result_beat;

    // Bit-accurate Ascon-128 model plus the queue of result beats it predicts.
    class aead_scoreboard;
        logic [63:0]  key_hi;
        logic [63:0]  key_lo;
        logic         decrypt;
        logic [63:0]  st[5];
        logic [63:0]  nonce_hold;
        t_aead_phase  ph;
        logic         hi_matched;
        t_result_beat beats_due[$];
        int           errors;

        function new();
            key_hi     = '0;
            key_lo     = '0;
            decrypt    = 1'b0;
            foreach (st[i]) st[i] = '0;
            nonce_hold = '0;
            ph         = ST_IDLE;
            hi_matched = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                asc_pkg::REG_KEY_HI: key_hi  = val;
                asc_pkg::REG_KEY_LO: key_lo  = val;
                asc_pkg::REG_DEC:    decrypt = val[0];
                default: ;
            endcase
        endfunction

        function logic [63:0] rotr(logic [63:0] v, int n);
            return (v >> n) | (v << (64 - n));
        endfunction

        function logic [63:0] lead_mask(logic [3:0] n);
            return {64{1'b1}} << (64 - 8 * int'(n));
        endfunction

        function logic [63:0] pad_after(logic [3:0] n);
            return asc_pkg::PAD_TOP >> (8 * int'(n));
        endfunction

        // the last `rounds` rounds of the 12-round schedule
        function void permute(int rounds);
            logic [63:0] t[5];
            for (int r = PERM_ROUNDS - rounds; r < PERM_ROUNDS; r++) begin
                st[2] ^= {56'd0, 4'(15 - r), 4'(r)};
                st[0] ^= st[4];
                st[4] ^= st[3];
                st[2] ^= st[1];
                for (int i = 0; i < 5; i++) t[i] = ~st[i] & st[(i + 1) % 5];
                for (int i = 0; i < 5; i++) st[i] ^= t[(i + 1) % 5];
                st[1] ^= st[0];
                st[0] ^= st[4];
                st[3] ^= st[2];
                st[2] = ~st[2];
                st[0] ^= rotr(st[0], 19) ^ rotr(st[0], 28);
                st[1] ^= rotr(st[1], 61) ^ rotr(st[1], 39);
                st[2] ^= rotr(st[2], 1) ^ rotr(st[2], 6);
                st[3] ^= rotr(st[3], 10) ^ rotr(st[3], 17);
                st[4] ^= rotr(st[4], 7) ^ rotr(st[4], 41);
            end
        endfunction

        function void close_ad();
            if (ph == ST_AD_MORE) begin
                st[0] ^= asc_pkg::PAD_TOP;
                permute(asc_pkg::DATA_ROUNDS);
            end
            if (ph == ST_AD_NEW || ph == ST_AD_MORE) begin
                st[4] ^= 64'd1;
                ph = ST_TEXT;
            end
        endfunction

        function void close_text();
            close_ad();
            if (ph == ST_TEXT) begin
                st[0] ^= asc_pkg::PAD_TOP;
                ph = ST_FIN_HI;
            end
        endfunction

        function void queue_beat(logic [63:0] d, logic [3:0] nb, logic tg, logic fin, logic ok);
            t_result_beat b;
            b.data   = d;
            b.nbytes = nb;
            b.is_tag = tg;
            b.fin    = fin;
            b.ok     = ok;
            beats_due.push_back(b);
        endfunction

        // advance the model by one accepted input beat
        function void take_beat(logic [2:0] cmd, logic [63:0] w, logic [3:0] bc, logic last);
            logic [3:0]  n;
            logic [63:0] res;
            logic [63:0] t;
            n = (!last || bc > 4'd8) ? 4'd8 : bc;
            case (cmd)
                asc_pkg::CMD_NONCE_HI: begin
                    nonce_hold = w;
                    ph = ST_NONCE;
                end
                asc_pkg::CMD_NONCE_LO: begin
                    if (ph == ST_NONCE) begin
                        st[0] = asc_pkg::ASCON_IV;
                        st[1] = key_hi;
                        st[2] = key_lo;
                        st[3] = nonce_hold;
                        st[4] = w;
                        permute(asc_pkg::INIT_ROUNDS);
                        st[3] ^= key_hi;
                        st[4] ^= key_lo;
                        ph = ST_AD_NEW;
                    end
                end
                asc_pkg::CMD_AD: begin
                    if (ph == ST_AD_NEW || ph == ST_AD_MORE) begin
                        if (n == 4'd8) begin
                            st[0] ^= w;
                            permute(asc_pkg::DATA_ROUNDS);
                            ph = ST_AD_MORE;
                        end else if (n != 4'd0) begin
                            st[0] ^= (w & lead_mask(n)) | pad_after(n);
                            permute(asc_pkg::DATA_ROUNDS);
                            ph = ST_AD_NEW;
                        end
                        if (last) close_ad();
                    end
                end
                asc_pkg::CMD_TEXT: begin
                    if (ph == ST_AD_NEW || ph == ST_AD_MORE || ph == ST_TEXT) begin
                        close_ad();
                        if (n == 4'd8) begin
                            if (decrypt) begin
                                res   = st[0] ^ w;
                                st[0] = w;
                            end else begin
                                st[0] ^= w;
                                res = st[0];
                            end
                            permute(asc_pkg::DATA_ROUNDS);
                            if (last) begin
                                st[0] ^= asc_pkg::PAD_TOP;
                                ph = ST_FIN_HI;
                            end
                        end else begin
                            if (decrypt) begin
                                res = (st[0] ^ w) & lead_mask(n);
                                st[0] ^= res | pad_after(n);
                            end else begin
                                st[0] ^= (w & lead_mask(n)) | pad_after(n);
                                res = st[0] & lead_mask(n);
                            end
                            ph = ST_FIN_HI;
                        end
                        queue_beat(res, n, 1'b0, 1'b0, 1'b0);
                    end
                end
                asc_pkg::CMD_FIN_HI: begin
                    if (ph >= ST_AD_NEW && ph <= ST_FIN_HI) begin
                        close_text();
                        st[1] ^= key_hi;
                        st[2] ^= key_lo;
                        permute(asc_pkg::INIT_ROUNDS);
                        t = st[3] ^ key_hi;
                        hi_matched = decrypt && (t == w);
                        ph = ST_FIN_LO;
                        queue_beat(t, 4'd8, 1'b1, 1'b0, 1'b0);
                    end
                end
                asc_pkg::CMD_FIN_LO: begin
                    if (ph == ST_FIN_LO) begin
                        t = st[4] ^ key_lo;
                        queue_beat(t, 4'd8, 1'b1, 1'b1, decrypt && hi_matched && (t == w));
                        ph = ST_IDLE;
                    end
                end
                default: ;
            endcase
        endfunction

        // tag the block would give now, without disturbing the model
        function void tag_now(output logic [63:0] hi, output logic [63:0] lo);
            logic [63:0] keep[5];
            t_aead_phase keep_ph;
            if (ph == ST_FIN_LO) begin
                hi = '0;
                lo = st[4] ^ key_lo;
                return;
            end
            keep    = st;
            keep_ph = ph;
            close_text();
            st[1] ^= key_hi;
            st[2] ^= key_lo;
            permute(asc_pkg::INIT_ROUNDS);
            hi = st[3] ^ key_hi;
            lo = st[4] ^ key_lo;
            st = keep;
            ph = keep_ph;
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= 200) $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        task match_beat(t_result_beat got);
            t_result_beat want;
            if (beats_due.size() == 0) begin
                report($sformatf("result beat with nothing expected, data %h", got.data));
                return;
            end
            want = beats_due.pop_front();
            if (got.data !== want.data)
                report($sformatf("data %h, want %h", got.data, want.data));
            if (got.nbytes !== want.nbytes)
                report($sformatf("out_bytes %0d, want %0d", got.nbytes, want.nbytes));
            if (got.is_tag !== want.is_tag)
                report($sformatf("is_tag %b, want %b", got.is_tag, want.is_tag));
            if (got.fin !== want.fin)
                report($sformatf("final_word %b, want %b", got.fin, want.fin));
            if (got.ok !== want.ok)
                report($sformatf("tag_ok %b, want %b", got.ok, want.ok));
        endtask
    endclass

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [asc_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;   // data_word, byte_count, pad
    logic [asc_pkg::IN_USER_W-1:0]      s_axis_tuser = '0;   // cmd
    logic                               s_axis_tlast = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [asc_pkg::OUT_DATA_W-1:0]     m_axis_tdata;        // data_out, out_bytes, tag_ok, pad
    logic                               m_axis_tuser;        // is_tag
    logic                               m_axis_tlast;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [asc_pkg::APB_ADDR_W-1:0]     paddr = '0;
    logic [asc_pkg::APB_DATA_W-1:0]     pwdata = '0;
    logic [asc_pkg::APB_DATA_W-1:0]     prdata;
    logic                               pready;

    aead_scoreboard sb = new();
    int             snd_idle = 13;
    int             rcv_idle = 81;
    bit             stall_req = 1'b0;
    bit             offering = 1'b0;
    int             fed_items;
    int             quiet_cycles = 0;

    ascon128_aead_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side: random backpressure, plus one long hold-off on request
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                hold = HOLD_CYCLES;
                stall_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    always @(posedge i_clk) begin : result_watch
        t_result_beat seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.data   = m_axis_tdata[63:0];
            seen.nbytes = m_axis_tdata[67:64];
            seen.ok     = m_axis_tdata[68];
            seen.is_tag = m_axis_tuser;
            seen.fin    = m_axis_tlast;
            sb.match_beat(seen);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one beat, hold it until taken, then maybe leave a gap
    task automatic send_beat(input logic [2:0] cmd, input logic [63:0] w,
                             input logic [3:0] bc, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, bc, w};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_beat(cmd, w, bc, last);
        if ($urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
    endtask

    // message beat, now and then preceded by a stray one
    task automatic feed(input logic [2:0] cmd, input logic [63:0] w,
                        input logic [3:0] bc, input logic last);
        if ($urandom_range(99) < 3)
            send_beat(3'($urandom_range(7)), {$urandom, $urandom},
                      4'($urandom_range(15)), 1'($urandom_range(1)));
        send_beat(cmd, w, bc, last);
        fed_items++;
    endtask

    task automatic settle();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [3:0] last_bytes();
        return ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    endfunction

    function automatic logic [63:0] tag_flip();
        return ($urandom_range(9) < 6) ? 64'd0 : (64'd1 << $urandom_range(63));
    endfunction

    task automatic random_message();
        int          n_ad;
        int          n_txt;
        bit          ad_closed;
        bit          txt_closed;
        logic [63:0] hi;
        logic [63:0] lo;
        n_ad       = $urandom_range(3);
        n_txt      = $urandom_range(4);
        ad_closed  = ($urandom_range(9) != 0);
        txt_closed = ($urandom_range(9) != 0);
        feed(asc_pkg::CMD_NONCE_HI, {$urandom, $urandom}, 4'($urandom_range(15)),
             1'($urandom_range(1)));
        feed(asc_pkg::CMD_NONCE_LO, {$urandom, $urandom}, 4'($urandom_range(15)),
             1'($urandom_range(1)));
        if (n_ad == 0 && ad_closed && $urandom_range(1))
            feed(asc_pkg::CMD_AD, {$urandom, $urandom}, 4'd0, 1'b1);
        for (int i = 0; i < n_ad; i++) begin
            if (i == n_ad - 1 && ad_closed)
                feed(asc_pkg::CMD_AD, {$urandom, $urandom}, last_bytes(), 1'b1);
            else
                feed(asc_pkg::CMD_AD, {$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
        end
        for (int i = 0; i < n_txt; i++) begin
            if (i == n_txt - 1 && txt_closed)
                feed(asc_pkg::CMD_TEXT, {$urandom, $urandom}, last_bytes(), 1'b1);
            else
                feed(asc_pkg::CMD_TEXT, {$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
        end
        // abandoned message: the next nonce starts over
        if ($urandom_range(19) == 0) return;
        sb.tag_now(hi, lo);
        feed(asc_pkg::CMD_FIN_HI, hi ^ tag_flip(), 4'($urandom_range(15)),
             1'($urandom_range(1)));
        sb.tag_now(hi, lo);
        feed(asc_pkg::CMD_FIN_LO, lo ^ tag_flip(), 4'($urandom_range(15)),
             1'($urandom_range(1)));
    endtask

    initial begin : stimulus
        logic [63:0] kh;
        logic [63:0] kl;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_write(asc_pkg::REG_KEY_HI, 64'd0);
        apb_write(asc_pkg::REG_KEY_LO, 64'd0);
        apb_write(asc_pkg::REG_DEC, 64'd0);

        // commands out of order or undefined: no effect
        send_beat(asc_pkg::CMD_TEXT, {64{1'b1}}, 4'd8, 1'b1);
        send_beat(CMD_RSVD6, {$urandom, $urandom}, 4'd15, 1'b1);
        send_beat(CMD_RSVD7, {$urandom, $urandom}, 4'd0, 1'b0);
        // empty AD via zero-byte last word; full last text word adds a padding block
        send_beat(asc_pkg::CMD_NONCE_HI, 64'd0, 4'd0, 1'b0);
        send_beat(asc_pkg::CMD_NONCE_LO, {64{1'b1}}, 4'd0, 1'b0);
        send_beat(asc_pkg::CMD_AD, {$urandom, $urandom}, 4'd0, 1'b1);
        send_beat(asc_pkg::CMD_TEXT, {64{1'b1}}, 4'd3, 1'b0);
        send_beat(asc_pkg::CMD_TEXT, {$urandom, $urandom}, 4'd8, 1'b1);
        send_beat(asc_pkg::CMD_FIN_HI, 64'd0, 4'd0, 1'b0);
        send_beat(asc_pkg::CMD_FIN_LO, 64'd0, 4'd0, 1'b0);
        // partial AD word, empty last text word
        send_beat(asc_pkg::CMD_NONCE_HI, {64{1'b1}}, 4'd8, 1'b1);
        send_beat(asc_pkg::CMD_NONCE_LO, 64'd0, 4'd8, 1'b1);
        send_beat(asc_pkg::CMD_AD, 64'd0, 4'd5, 1'b0);
        send_beat(asc_pkg::CMD_AD, {$urandom, $urandom}, 4'd3, 1'b1);
        send_beat(asc_pkg::CMD_TEXT, {$urandom, $urandom}, 4'd0, 1'b1);
        send_beat(asc_pkg::CMD_FIN_HI, {64{1'b1}}, 4'd8, 1'b1);
        send_beat(asc_pkg::CMD_FIN_LO, {64{1'b1}}, 4'd8, 1'b1);
        // text right after init, byte count above eight; new nonce drops the low tag half
        send_beat(asc_pkg::CMD_NONCE_HI, {$urandom, $urandom}, 4'd0, 1'b0);
        send_beat(asc_pkg::CMD_NONCE_LO, {$urandom, $urandom}, 4'd0, 1'b0);
        send_beat(asc_pkg::CMD_TEXT, {$urandom, $urandom}, 4'd15, 1'b1);
        send_beat(asc_pkg::CMD_FIN_HI, {$urandom, $urandom}, 4'd0, 1'b0);
        send_beat(asc_pkg::CMD_NONCE_HI, {$urandom, $urandom}, 4'd0, 1'b0);
        send_beat(asc_pkg::CMD_FIN_LO, {$urandom, $urandom}, 4'd0, 1'b0);
        // AD and text both left open, closed by the high tag request
        send_beat(asc_pkg::CMD_NONCE_LO, {$urandom, $urandom}, 4'd0, 1'b0);
        send_beat(asc_pkg::CMD_AD, {$urandom, $urandom}, 4'd2, 1'b0);
        send_beat(asc_pkg::CMD_FIN_HI, {$urandom, $urandom}, 4'd0, 1'b0);
        send_beat(asc_pkg::CMD_FIN_LO, {$urandom, $urandom}, 4'd0, 1'b0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            case (seg)
                0: begin
                    kh = {64{1'b1}};
                    kl = {64{1'b1}};
                end
                1: begin
                    kh = 64'd0;
                    kl = {$urandom, $urandom};
                end
                3: begin
                    kh = {$urandom, $urandom};
                    kl = 64'd0;
                end
                default: begin
                    kh = {$urandom, $urandom};
                    kl = {$urandom, $urandom};
                end
            endcase
            apb_write(asc_pkg::REG_KEY_HI, kh);
            apb_write(asc_pkg::REG_KEY_LO, kl);
            apb_write(asc_pkg::REG_DEC, {63'd0, seg % 2 == 0});
            snd_idle = (seg < 2) ? 13 : (seg < 4) ? 81 : 0;
            rcv_idle = (seg < 2) ? 81 : (seg < 4) ? 13 : 0;
            // long receiver hold-off with the sender still pushing
            if (seg == 4) stall_req = 1'b1;
            fed_items = 0;
            while (fed_items < SEG_ITEMS) random_message();
        end

        settle();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
